@@ hw/rtl/pbei_pkg.sv @@
package pbei_pkg;

	localparam int EDGE_COUNT = 12;
	localparam int QBITS      = 17;

	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MIN_Y = 3'd1;
	localparam logic [2:0] REG_MIN_Z = 3'd2;
	localparam logic [2:0] REG_MAX_X = 3'd3;
	localparam logic [2:0] REG_MAX_Y = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;

	localparam logic [1:0] EDGE_AXIS [EDGE_COUNT] =
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2};
	localparam logic [2:0] EDGE_SEL [EDGE_COUNT] =
		'{3'd0, 3'd2, 3'd4, 3'd6, 3'd0, 3'd1, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3};

	localparam logic [3:0] LAST_EDGE = 4'(EDGE_COUNT - 1);

	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
		logic signed [31:0] na;
		logic signed [32:0] d;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic [1:0]         axis;
		logic [3:0]         idx;
		logic               tail;
	} edge_item_t;

	typedef struct packed {
		logic [66:0]        rem;
		logic [64:0]        den;
		logic [QBITS-1:0]   q;
		logic               neg;
		logic               drop;
		logic signed [32:0] d;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic [1:0]         axis;
		logic [3:0]         idx;
		logic               tail;
	} div_item_t;

endpackage

@@ hw/rtl/pbei_edge_gen.sv @@
module pbei_edge_gen import pbei_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [191:0]       in_data,
	input  logic signed [31:0] lo [3],
	input  logic signed [31:0] hi [3],
	output logic               out_valid,
	output edge_item_t         out_item
);

	logic               busy_q;
	logic [3:0]         edge_q;
	logic signed [31:0] n_q [3];
	logic signed [31:0] p_q [3];
	logic signed [31:0] o [3];
	logic [1:0]         a;
	logic               accept;
	edge_item_t         item;

	assign in_ready = en && (!busy_q || edge_q == LAST_EDGE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		a = EDGE_AXIS[edge_q];
		for (int i = 0; i < 3; i++) begin
			o[i] = EDGE_SEL[edge_q][i] ? hi[i] : lo[i];
		end
		item.nx   = n_q[0];
		item.ny   = n_q[1];
		item.nz   = n_q[2];
		item.dx   = 33'(p_q[0]) - 33'(o[0]);
		item.dy   = 33'(p_q[1]) - 33'(o[1]);
		item.dz   = 33'(p_q[2]) - 33'(o[2]);
		item.na   = n_q[a];
		item.d    = 33'(hi[a]) - 33'(lo[a]);
		item.ox   = o[0];
		item.oy   = o[1];
		item.oz   = o[2];
		item.axis = a;
		item.idx  = edge_q;
		item.tail = (edge_q == LAST_EDGE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			edge_q    <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= busy_q;
			if (accept) begin
				busy_q <= 1'b1;
				edge_q <= '0;
			end else if (busy_q) begin
				if (edge_q == LAST_EDGE) begin
					busy_q <= 1'b0;
					edge_q <= '0;
				end else begin
					edge_q <= edge_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item <= item;
			if (accept) begin
				for (int i = 0; i < 3; i++) begin
					n_q[i] <= in_data[32*i +: 32];
					p_q[i] <= in_data[96 + 32*i +: 32];
				end
			end
		end
	end

endmodule

@@ hw/rtl/pbei_front.sv @@
module pbei_front import pbei_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  edge_item_t in_item,
	output logic       out_valid,
	output div_item_t  out_item
);

	logic               v_s2, v_s3;
	logic signed [65:0] px_s2, py_s2, pz_s2, vd_s2, vd_s3;
	logic signed [66:0] num_s3;
	edge_item_t         it_s2, it_s3;
	logic [66:0]        nmag;
	logic [65:0]        vmag;
	div_item_t          di;

	always_comb begin
		nmag = num_s3[66] ? 67'(-num_s3) : 67'(num_s3);
		vmag = vd_s3[65] ? 66'(-vd_s3) : 66'(vd_s3);
		di.rem  = nmag;
		di.den  = vmag[64:0];
		di.q    = '0;
		di.neg  = num_s3[66] ^ vd_s3[65];
		di.drop = (vd_s3 == '0) || (nmag >= {vmag, 1'b0});
		di.d    = it_s3.d;
		di.ox   = it_s3.ox;
		di.oy   = it_s3.oy;
		di.oz   = it_s3.oz;
		di.axis = it_s3.axis;
		di.idx  = it_s3.idx;
		di.tail = it_s3.tail;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s2      <= in_valid;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2    <= in_item.nx * in_item.dx;
			py_s2    <= in_item.ny * in_item.dy;
			pz_s2    <= in_item.nz * in_item.dz;
			vd_s2    <= in_item.na * in_item.d;
			it_s2    <= in_item;
			num_s3   <= 67'(px_s2) + 67'(py_s2) + 67'(pz_s2);
			vd_s3    <= vd_s2;
			it_s3    <= it_s2;
			out_item <= di;
		end
	end

endmodule

@@ hw/rtl/pbei_div_step.sv @@
module pbei_div_step import pbei_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  div_item_t in_item,
	output logic      out_valid,
	output div_item_t out_item
);

	logic        ge;
	logic [66:0] rn;
	div_item_t   nx;

	always_comb begin
		ge     = in_item.rem >= 67'(in_item.den);
		rn     = ge ? in_item.rem - 67'(in_item.den) : in_item.rem;
		nx     = in_item;
		nx.rem = {rn[65:0], 1'b0};
		nx.q   = {in_item.q[QBITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item <= nx;
		end
	end

endmodule

@@ hw/rtl/pbei_out.sv @@
module pbei_out import pbei_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	output logic         en,
	input  logic         in_valid,
	input  div_item_t    in_item,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tlast,
	output logic         m_axis_tuser
);

	logic               va_s1, hit_s1, tail_s1;
	logic signed [50:0] step_s1;
	logic signed [31:0] o_s1 [3];
	logic [1:0]         axis_s1;
	logic [3:0]         idx_s1;
	logic               vb_s2, hit_s2, tail_s2;
	logic signed [31:0] pt_s2 [3];
	logic [3:0]         idx_s2;

	logic               pend_v_q, pend_done_q;
	logic signed [31:0] pend_pt_q [3];
	logic [3:0]         pend_idx_q, pend_cnt_q, cnt_q;

	logic               hit_a;
	logic [50:0]        smag;
	logic [31:0]        mag;
	logic signed [31:0] pt_b [3];

	logic               emit, e_found, e_last;
	logic signed [31:0] e_pt [3];
	logic [3:0]         e_idx, e_cnt;
	logic               pv_n, pd_n;
	logic [3:0]         cnt_n;

	assign en = !m_axis_tvalid || m_axis_tready;

	always_comb begin
		hit_a = !in_item.drop &&
			(in_item.q == '0 || (!in_item.neg && in_item.q <= 17'd65536));
		smag  = step_s1[50] ? 51'(-step_s1) : 51'(step_s1);
		mag   = smag[47:16];
		for (int i = 0; i < 3; i++) begin
			pt_b[i] = o_s1[i];
		end
		pt_b[axis_s1] = o_s1[axis_s1] + (step_s1[50] ? -mag : mag);
	end

	always_comb begin
		emit    = 1'b0;
		e_found = 1'b1;
		e_last  = 1'b0;
		e_pt    = pend_pt_q;
		e_idx   = pend_idx_q;
		e_cnt   = pend_cnt_q;
		pv_n    = pend_v_q;
		pd_n    = pend_done_q;
		cnt_n   = cnt_q;
		if (pend_v_q && pend_done_q) begin
			emit   = 1'b1;
			e_last = 1'b1;
			pv_n   = 1'b0;
			pd_n   = 1'b0;
		end
		if (vb_s2) begin
			if (hit_s2) begin
				cnt_n = cnt_q + 4'd1;
				if (pv_n) begin
					emit = 1'b1;
				end
				if (tail_s2 && !pv_n) begin
					emit    = 1'b1;
					e_last  = 1'b1;
					e_pt    = pt_s2;
					e_idx   = idx_s2;
					e_cnt   = cnt_n;
					pv_n    = 1'b0;
				end else begin
					pd_n = tail_s2;
					pv_n = 1'b1;
				end
			end else if (tail_s2) begin
				emit   = 1'b1;
				e_last = 1'b1;
				if (!pv_n) begin
					e_found = 1'b0;
					e_idx   = '0;
					e_cnt   = '0;
					for (int i = 0; i < 3; i++) begin
						e_pt[i] = '0;
					end
				end
				pv_n = 1'b0;
			end
			if (tail_s2) begin
				cnt_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s1         <= 1'b0;
			vb_s2         <= 1'b0;
			pend_v_q      <= 1'b0;
			pend_done_q   <= 1'b0;
			cnt_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			va_s1         <= in_valid;
			vb_s2         <= va_s1;
			pend_v_q      <= pv_n;
			pend_done_q   <= pd_n;
			cnt_q         <= cnt_n;
			m_axis_tvalid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1  <= hit_a;
			tail_s1 <= in_item.tail;
			step_s1 <= in_item.d * $signed({1'b0, in_item.q});
			o_s1[0] <= in_item.ox;
			o_s1[1] <= in_item.oy;
			o_s1[2] <= in_item.oz;
			axis_s1 <= in_item.axis;
			idx_s1  <= in_item.idx;
			hit_s2  <= hit_s1;
			tail_s2 <= tail_s1;
			pt_s2   <= pt_b;
			idx_s2  <= idx_s1;
			if (vb_s2 && hit_s2) begin
				pend_pt_q  <= pt_s2;
				pend_idx_q <= idx_s2;
				pend_cnt_q <= cnt_q + 4'd1;
			end
			m_axis_tdata <= {e_cnt, e_idx, e_pt[2], e_pt[1], e_pt[0]};
			m_axis_tlast <= e_last;
			m_axis_tuser <= e_found;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[103:96] == '0)
		else $error("no-hit result must be last with zero count and index");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[103:100] != '0)
		else $error("hit result with zero point count");
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_done_q |-> pend_v_q)
		else $error("closed plane without a held point");
	assert property (@(posedge clk) disable iff (!arst_n)
		en && vb_s2 && tail_s2 |=> cnt_q == '0)
		else $error("point count not cleared at end of plane");

endmodule

@@ hw/rtl/plane_box_edge_intersect.sv @@
// Plane against axis-aligned box: each plane (normal, point on plane) is tested against the
// twelve box edges, one edge per clock while the output is not stalled; the edge sequencer
// takes the next plane while it issues the current plane's last edge. A plane yields one
// transfer per hit edge (found set, point_count running, tlast on the final one), or a single
// transfer with found clear when nothing is hit. Each edge passes the edge sequencer register,
// a three-stage dot-product front end, a 17-stage restoring divider (one quotient bit per
// stage) and three stages of point reconstruction and output. Each hit is held until the next
// hit or the plane's last edge shows whether it is the final one. Box bounds are to be written
// through the cfg port only while no plane is in flight; the user must keep to this, as the
// block itself does not enforce it.
module plane_box_edge_intersect import pbei_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// normal_x, normal_y, normal_z, origin_x, origin_y, origin_z
	input  logic [191:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// point_x, point_y, point_z, edge_index, point_count
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tlast,
	// found
	output logic         m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	logic signed [31:0] lo_q [3];
	logic signed [31:0] hi_q [3];
	logic               en;
	logic               e_valid;
	edge_item_t         e_item;
	logic               dv [QBITS+1];
	div_item_t          di [QBITS+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q[0] <= '0;
			lo_q[1] <= '0;
			lo_q[2] <= '0;
			hi_q[0] <= 32'h0100_0000;
			hi_q[1] <= 32'h0100_0000;
			hi_q[2] <= 32'h0100_0000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_X: lo_q[0] <= cfg_data;
				REG_MIN_Y: lo_q[1] <= cfg_data;
				REG_MIN_Z: lo_q[2] <= cfg_data;
				REG_MAX_X: hi_q[0] <= cfg_data;
				REG_MAX_Y: hi_q[1] <= cfg_data;
				REG_MAX_Z: hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	pbei_edge_gen u_edge_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.lo        (lo_q),
		.hi        (hi_q),
		.out_valid (e_valid),
		.out_item  (e_item)
	);

	pbei_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (e_valid),
		.in_item   (e_item),
		.out_valid (dv[0]),
		.out_item  (di[0])
	);

	for (genvar g = 0; g < QBITS; g++) begin : g_div
		pbei_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv[g]),
			.in_item   (di[g]),
			.out_valid (dv[g+1]),
			.out_item  (di[g+1])
		);
	end

	pbei_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (dv[QBITS]),
		.in_item       (di[QBITS]),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

@@ test/tb_plane_box_edge_intersect.sv @@
module tb_plane_box_edge_intersect;
	import pbei_pkg::*;

	typedef struct {
		logic signed [31:0] n [3];
		logic signed [31:0] p [3];
	} plane_t;

	typedef struct {
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [3:0]  idx;
		logic        found;
		logic [3:0]  cnt;
		logic        last;
	} hit_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic         m_axis_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	logic signed [31:0] box_lo [3];
	logic signed [31:0] box_hi [3];
	hit_t pending_points [$];
	int   error_count = 0;
	bit   calm = 1'b0;
	int   hold_requests = 0;

	plane_box_edge_intersect dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic void predict_plane_hits(input plane_t pl);
		logic signed [127:0] n [3];
		logic signed [127:0] p [3];
		logic signed [127:0] lo [3];
		logic signed [127:0] hi [3];
		logic signed [127:0] o [3];
		logic signed [127:0] d, vd, num, an, ad, q, step, mag;
		int   a;
		int   cnt;
		bit   neg;
		hit_t h;
		cnt = 0;
		for (int i = 0; i < 3; i++) begin
			n[i] = pl.n[i];
			p[i] = pl.p[i];
			lo[i] = box_lo[i];
			hi[i] = box_hi[i];
		end
		for (int e = 0; e < EDGE_COUNT; e++) begin
			a = EDGE_AXIS[e];
			for (int i = 0; i < 3; i++)
				o[i] = EDGE_SEL[e][i] ? hi[i] : lo[i];
			d = hi[a] - lo[a];
			vd = n[a] * d;
			if (vd == 0)
				continue;
			num = 0;
			for (int i = 0; i < 3; i++)
				num += n[i] * (p[i] - o[i]);
			an = (num < 0) ? -num : num;
			ad = (vd < 0) ? -vd : vd;
			neg = (num < 0) != (vd < 0);
			if ((an <<< 16) >= (ad <<< 17))
				continue;
			q = (an <<< 16) / ad;
			if (q != 0 && (neg || q > 65536))
				continue;
			step = d * q;
			mag = ((step < 0) ? -step : step) / 65536;
			o[a] = (step < 0) ? o[a] - mag : o[a] + mag;
			cnt++;
			h.px = o[0][31:0];
			h.py = o[1][31:0];
			h.pz = o[2][31:0];
			h.idx = 4'(e);
			h.found = 1'b1;
			h.cnt = 4'(cnt);
			h.last = 1'b0;
			pending_points = {pending_points, h};
		end
		if (cnt == 0) begin
			h = '{default: '0};
			h.last = 1'b1;
			pending_points = {pending_points, h};
		end else begin
			pending_points[pending_points.size() - 1].last = 1'b1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int hold_left;
		int hold_seen;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left = 0;
			hold_seen = 0;
		end else if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = 400;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= 7);
		end
	end

	always @(posedge clk) begin
		hit_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_points.size() == 0) begin
				report_mismatch("unexpected transfer", m_axis_tdata[31:0], '0);
			end else begin
				want = pending_points.pop_front();
				if (m_axis_tdata[31:0] !== want.px)
					report_mismatch("point_x", m_axis_tdata[31:0], want.px);
				if (m_axis_tdata[63:32] !== want.py)
					report_mismatch("point_y", m_axis_tdata[63:32], want.py);
				if (m_axis_tdata[95:64] !== want.pz)
					report_mismatch("point_z", m_axis_tdata[95:64], want.pz);
				if (m_axis_tdata[99:96] !== want.idx)
					report_mismatch("edge_index", 32'(m_axis_tdata[99:96]), 32'(want.idx));
				if (m_axis_tdata[103:100] !== want.cnt)
					report_mismatch("point_count", 32'(m_axis_tdata[103:100]),
						32'(want.cnt));
				if (m_axis_tuser !== want.found)
					report_mismatch("found", 32'(m_axis_tuser), 32'(want.found));
				if (m_axis_tlast !== want.last)
					report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
			end
		end
	end

	task automatic send_plane(input plane_t pl);
		if (!calm)
			while ($urandom_range(99) < 7) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pl.p[2], pl.p[1], pl.p[0], pl.n[2], pl.n[1], pl.n[0]};
		do @(posedge clk); while (!s_axis_tready);
		predict_plane_hits(pl);
	endtask

	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// write all six bounds in one burst: min x,y,z then max x,y,z
	task automatic load_box(input logic signed [31:0] lo [3], input logic signed [31:0] hi [3]);
		logic [31:0] vals [6];
		logic [2:0]  regs [6];
		vals = '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
		regs = '{REG_MIN_X, REG_MIN_Y, REG_MIN_Z, REG_MAX_X, REG_MAX_Y, REG_MAX_Z};
		drain_block();
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		box_lo = lo;
		box_hi = hi;
	endtask

	function automatic plane_t make_plane(input logic signed [31:0] nx, ny, nz, px, py, pz);
		plane_t pl;
		pl.n = '{nx, ny, nz};
		pl.p = '{px, py, pz};
		return pl;
	endfunction

	function automatic logic [31:0] pick_between(input logic signed [31:0] a,
		input logic signed [31:0] b);
		longint l, h;
		l = (a < b) ? a : b;
		h = (a < b) ? b : a;
		return 32'(l + longint'($urandom) % (h - l + 1));
	endfunction

	function automatic logic [31:0] pick_normal();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(262144)) - 131072);
			2: return $urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000;
			default: return ($urandom_range(3) == 0) ? 32'd0 : $urandom;
		endcase
	endfunction

	function automatic plane_t random_plane();
		plane_t pl;
		bit well_formed;
		well_formed = $urandom_range(99) < 75;
		for (int i = 0; i < 3; i++) begin
			pl.n[i] = pick_normal();
			pl.p[i] = well_formed ? pick_between(box_lo[i], box_hi[i]) : $urandom;
		end
		return pl;
	endfunction

	task automatic test_reset_box();
		send_plane(make_plane(32'h0001_0000, 0, 0, 32'h0080_0000, 0, 0));
		send_plane(make_plane(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0));
		send_plane(make_plane(32'h0001_0000, 32'h0001_0000, 0, 32'h0100_0000, 0, 0));
		send_plane(make_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h0040_0000, 32'h0040_0000, 32'h0040_0000));
		send_plane(make_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
		send_plane(make_plane(32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff,
			32'h0012_3456, 32'h00ab_cdef, 32'h0001_0001));
	endtask

	task automatic test_special_cases();
		send_plane(make_plane(0, 0, 0, 32'h0010_0000, 0, 0));
		send_plane(make_plane(32'h0001_0000, 0, 0, 32'h7fff_ffff, 0, 0));
		send_plane(make_plane(0, 0, 32'h0001_0000, 0, 0, 32'h0020_0000));
		send_plane(make_plane(32'h0001_0000, 0, 0, 32'hffff_ffff, 0, 0));
		send_plane(make_plane(32'h0000_0003, 32'h0000_0007, 0, 32'h0000_0001, 0, 0));
	endtask

	task automatic test_box_settings();
		logic signed [31:0] lo [3];
		logic signed [31:0] hi [3];
		lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		hi = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
		load_box(lo, hi);
		send_plane(make_plane(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0));
		send_plane(make_plane(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001,
			32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678));
		lo = '{32'h0100_0000, 32'h0200_0000, 32'h0300_0000};
		hi = '{32'hff00_0000, 32'hfe00_0000, 32'hfd00_0000};
		load_box(lo, hi);
		send_plane(make_plane(32'h0001_0000, 32'h0000_8000, 32'hffff_0000, 0, 0, 0));
		send_plane(make_plane(0, 32'h0001_0000, 0, 0, 32'h0100_0000, 0));
		lo = '{32'h0010_0000, 32'hfff0_0000, 32'h0000_0000};
		hi = '{32'h0010_0000, 32'h0010_0000, 32'h0000_0000};
		load_box(lo, hi);
		send_plane(make_plane(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0010_0000, 0, 0));
		send_plane(make_plane(32'h0001_0000, 0, 0, 32'h0010_0000, 0, 0));
	endtask

	task automatic test_random(input int count);
		logic signed [31:0] lo [3];
		logic signed [31:0] hi [3];
		for (int k = 0; k < count; k++) begin
			if (k % 25 == 0) begin
				for (int i = 0; i < 3; i++) begin
					lo[i] = ($urandom_range(1)) ? $urandom :
						32'($signed($urandom_range(65536 * 512)) - 65536 * 256);
					hi[i] = ($urandom_range(3) == 0) ? $urandom :
						lo[i] + 32'($urandom_range(65536 * 512));
				end
				load_box(lo, hi);
			end
			calm = (k % 25) < 10;
			send_plane(random_plane());
		end
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		hold_requests++;
		for (int k = 0; k < 25; k++)
			send_plane(random_plane());
	endtask

	initial begin
		for (int i = 0; i < 3; i++) begin
			box_lo[i] = 32'h0000_0000;
			box_hi[i] = 32'h0100_0000;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_box();
		test_special_cases();
		test_box_settings();
		test_random(88);
		test_backpressure();
		drain_block();
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
